[hdl/assert_macros.svh]
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLKD(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif

`endif

[hdl/mlpt_pkg.sv]
package mlpt_pkg;

   localparam int WEIGHT_WIDTH  = 24;
   localparam int FRACTION_BITS = 16;
   localparam int NW            = 9;
   localparam int LR_WIDTH      = 16;
   localparam int LR_SHIFT      = 16;
   localparam int ZW            = WEIGHT_WIDTH + 2;
   localparam int DW            = ((ZW > FRACTION_BITS + 1) ? ZW : FRACTION_BITS + 1)
                                  + FRACTION_BITS;
   localparam int CNT_W         = $clog2(DW + 1);
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;

   localparam logic [LR_WIDTH-1:0] LR_RESET = LR_WIDTH'(22938);
   localparam logic [CSR_AW-1:0]   ADDR_LR  = '0;

   localparam logic [ZW-1:0] ONE  = ZW'(64'd1 << FRACTION_BITS);
   localparam logic [ZW-1:0] HALF = ZW'(64'd1 << (FRACTION_BITS - 1));

   localparam int IX_W00 = 0;
   localparam int IX_W01 = 1;
   localparam int IX_W10 = 2;
   localparam int IX_W11 = 3;
   localparam int IX_B10 = 4;
   localparam int IX_B11 = 5;
   localparam int IX_W20 = 6;
   localparam int IX_W21 = 7;
   localparam int IX_B2  = 8;

   typedef enum logic [1:0] {
      OP_MULQ,
      OP_MULLR,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic                 start;
      arith_op_type         op;
      logic signed [ZW-1:0] a;
      logic signed [ZW-1:0] b;
      logic [DW-1:0]        num;
      logic [ZW-1:0]        den;
   } arith_req_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT,
      S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      ST_H0, ST_H1, ST_P0, ST_ZO, ST_Y,
      ST_DZO1, ST_DZO2, ST_DY, ST_G, ST_W6, ST_W7,
      ST_T0, ST_DZ01, ST_DZ02, ST_DH0, ST_S0,
      ST_T1, ST_DZ11, ST_DZ12, ST_DH1, ST_S1
   } step_type;

   function automatic logic signed [WEIGHT_WIDTH-1:0] init_weight(input int tenths);
      longint m;
      longint r;
      longint hi;
      m  = (tenths < 0 ? -longint'(tenths) : longint'(tenths)) << FRACTION_BITS;
      r  = (m + 5) / 10;
      hi = (longint'(1) << (WEIGHT_WIDTH - 1)) - 1;
      if (r > hi) r = hi;
      return WEIGHT_WIDTH'(tenths < 0 ? -r : r);
   endfunction

   function automatic logic [ZW-1:0] mag(input logic signed [ZW-1:0] v);
      return v[ZW-1] ? ZW'(-v) : ZW'(v);
   endfunction

   function automatic logic signed [WEIGHT_WIDTH-1:0] sat_w(input logic signed [ZW:0] v);
      logic signed [ZW:0] hi;
      logic signed [ZW:0] lo;
      hi = (ZW+1)'((64'd1 << (WEIGHT_WIDTH - 1)) - 64'd1);
      lo = -hi - (ZW+1)'(1);
      if (v > hi) return WEIGHT_WIDTH'(hi);
      if (v < lo) return WEIGHT_WIDTH'(lo);
      return WEIGHT_WIDTH'(v);
   endfunction

   function automatic logic [15:0] to_q16(input logic [FRACTION_BITS-1:0] y);
      if (FRACTION_BITS >= 16) return 16'(y >> (FRACTION_BITS - 16));
      else return 16'(32'(y) << (16 - FRACTION_BITS));
   endfunction

endpackage

[hdl/mlpt_arith.sv]
module mlpt_arith import mlpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  arith_req_type        req,
   output logic                 done,
   output logic signed [ZW-1:0] result
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   arith_op_type         op_ff, op_in;
   logic signed [ZW-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [ZW-1:0] res_ff, res_in;
   logic [DW-1:0]        num_ff, num_in;
   logic [ZW-1:0]        den_ff, den_in;
   logic [ZW-1:0]        rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [2*ZW-1:0] prod;
   logic [2*ZW:0]   rnd;
   logic [ZW-1:0]   pmag;
   logic [ZW:0]     rsh;
   logic            neg;

   always_comb begin
      prod = mag(a_ff) * mag(b_ff);
      neg  = a_ff[ZW-1] ^ b_ff[ZW-1];
      if (op_ff == OP_MULLR) begin
         rnd = ((2*ZW+1)'(prod) + ((2*ZW+1)'(1) << (LR_SHIFT - 1))) >> LR_SHIFT;
      end else begin
         rnd = ((2*ZW+1)'(prod) + ((2*ZW+1)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
      end
      pmag = rnd[ZW-1:0];
      rsh  = {rem_ff, num_ff[DW-1]};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      res_in  = res_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         a_in    = req.a;
         b_in    = req.b;
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         cnt_in  = CNT_W'(DW);
      end else if (busy_ff) begin
         case (op_ff)
            OP_DIV: begin
               if (rsh >= {1'b0, den_ff}) begin
                  rem_in = ZW'(rsh - {1'b0, den_ff});
                  num_in = {num_ff[DW-2:0], 1'b1};
               end else begin
                  rem_in = rsh[ZW-1:0];
                  num_in = {num_ff[DW-2:0], 1'b0};
               end
               cnt_in = cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) begin
                  busy_in = 1'b0;
                  done_in = 1'b1;
                  res_in  = num_in[ZW-1:0];
               end
            end
            OP_MULQ, OP_MULLR: begin
               busy_in = 1'b0;
               done_in = 1'b1;
               res_in  = neg ? -$signed(pmag) : $signed(pmag);
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[hdl/mlp_two_two_one_online_trainer_core.sv]
// Sequence: an input beat runs three divisions and two multiplies on the shared arithmetic
// unit, then an emit step that waits for the response channel; a train beat then runs the update steps.
// A new beat is accepted only in idle, after the previous beat's sequence has finished;
// one sequencer drives the shared unit, which holds a bit-serial divider and a multiplier.
// Reset: synchronous, active high; weights and learning rate return to initial values.
`include "assert_macros.svh"

module mlp_two_two_one_online_trainer_core import mlpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // first_bit, second_bit, target
   input  logic              req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // predicted, output_value[15:0]
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic signed [WEIGHT_WIDTH-1:0] w_ff [NW];
   logic signed [WEIGHT_WIDTH-1:0] w_in [NW];
   logic [LR_WIDTH-1:0] lr_ff, lr_in;

   logic train_ff, train_in, x0_ff, x0_in, x1_ff, x1_in, tgt_ff, tgt_in;
   logic signed [ZW-1:0] z0_ff, z0_in, z1_ff, z1_in, zo_ff, zo_in;
   logic signed [ZW-1:0] h0_ff, h0_in, h1_ff, h1_in, y_ff, y_in;
   logic signed [ZW-1:0] tmp_ff, tmp_in, d1_ff, d1_in, dz_ff, dz_in;
   logic signed [ZW-1:0] dy_ff, dy_in, g_ff, g_in;
   logic signed [WEIGHT_WIDTH-1:0] ow0_ff, ow0_in, ow1_ff, ow1_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_data_ff, rsp_data_in;

   arith_req_type        areq;
   logic                 adone;
   logic signed [ZW-1:0] ares;

   logic                 accept, out_free, wr_lr;
   logic signed [ZW-1:0] zsel, lrs, hval, s;
   logic [ZW-1:0]        zm;

   mlpt_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (areq),
      .done   (adone),
      .result (ares)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_LR) ? CSR_DW'(lr_ff) : '0;
   assign wr_lr      = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr == ADDR_LR);
   assign lrs        = ZW'(lr_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_ISSUE;
               step_in  = ST_H0;
            end
         end
         S_ISSUE: state_in = S_WAIT;
         S_WAIT: begin
            if (adone) begin
               if (step_ff == ST_Y) begin
                  state_in = S_EMIT;
               end else if (step_ff == ST_S1) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_ISSUE;
                  step_in  = step_type'(step_ff + 5'd1);
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               state_in = train_ff ? S_ISSUE : S_IDLE;
               step_in  = ST_DZO1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // shared unit operands
   always_comb begin
      case (step_ff)
         ST_H0, ST_DZ01, ST_DZ02: zsel = z0_ff;
         ST_H1, ST_DZ11, ST_DZ12: zsel = z1_ff;
         default:                 zsel = zo_ff;
      endcase
      zm        = mag(zsel);
      areq      = '0;
      areq.start = (state_ff == S_ISSUE);
      areq.den  = ONE + zm;
      case (step_ff)
         ST_H0, ST_H1, ST_Y: begin
            areq.op  = OP_DIV;
            areq.num = DW'(zm) << (FRACTION_BITS - 1);
         end
         ST_DZO1, ST_DZ01, ST_DZ11: begin
            areq.op  = OP_DIV;
            areq.num = DW'(1) << (2*FRACTION_BITS - 1);
         end
         ST_DZO2, ST_DZ02, ST_DZ12: begin
            areq.op  = OP_DIV;
            areq.num = DW'(d1_ff) << FRACTION_BITS;
         end
         ST_P0: begin
            areq.op = OP_MULQ; areq.a = ZW'(w_ff[IX_W20]); areq.b = h0_ff;
         end
         ST_ZO: begin
            areq.op = OP_MULQ; areq.a = ZW'(w_ff[IX_W21]); areq.b = h1_ff;
         end
         ST_DY: begin
            areq.op = OP_MULQ; areq.a = y_ff - (tgt_ff ? $signed(ONE) : '0); areq.b = dz_ff;
         end
         ST_G: begin
            areq.op = OP_MULLR; areq.a = dy_ff; areq.b = lrs;
         end
         ST_W6: begin
            areq.op = OP_MULQ; areq.a = g_ff; areq.b = h0_ff;
         end
         ST_W7: begin
            areq.op = OP_MULQ; areq.a = g_ff; areq.b = h1_ff;
         end
         ST_T0: begin
            areq.op = OP_MULQ; areq.a = dy_ff; areq.b = ZW'(ow0_ff);
         end
         ST_T1: begin
            areq.op = OP_MULQ; areq.a = dy_ff; areq.b = ZW'(ow1_ff);
         end
         ST_DH0, ST_DH1: begin
            areq.op = OP_MULQ; areq.a = tmp_ff; areq.b = dz_ff;
         end
         ST_S0, ST_S1: begin
            areq.op = OP_MULLR; areq.a = tmp_ff; areq.b = lrs;
         end
         default: areq.op = OP_MULQ;
      endcase
   end

   // datapath updates
   always_comb begin
      w_in         = w_ff;
      lr_in        = wr_lr ? csr_pwdata[LR_WIDTH-1:0] : lr_ff;
      train_in     = train_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      tgt_in       = tgt_ff;
      z0_in        = z0_ff;
      z1_in        = z1_ff;
      zo_in        = zo_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      y_in         = y_ff;
      tmp_in       = tmp_ff;
      d1_in        = d1_ff;
      dz_in        = dz_ff;
      dy_in        = dy_ff;
      g_in         = g_ff;
      ow0_in       = ow0_ff;
      ow1_in       = ow1_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      hval         = $signed(HALF) + (zsel[ZW-1] ? -ares : ares);
      s            = ares;
      if (accept) begin
         train_in = req_tuser;
         x0_in    = req_tdata[0];
         x1_in    = req_tdata[1];
         tgt_in   = req_tdata[2];
         z0_in    = ZW'(w_ff[IX_B10]) + (req_tdata[0] ? ZW'(w_ff[IX_W00]) : '0)
                    + (req_tdata[1] ? ZW'(w_ff[IX_W01]) : '0);
         z1_in    = ZW'(w_ff[IX_B11]) + (req_tdata[0] ? ZW'(w_ff[IX_W10]) : '0)
                    + (req_tdata[1] ? ZW'(w_ff[IX_W11]) : '0);
         ow0_in   = w_ff[IX_W20];
         ow1_in   = w_ff[IX_W21];
      end
      if (state_ff == S_EMIT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {to_q16(y_ff[FRACTION_BITS-1:0]), (y_ff >= $signed(HALF))};
      end
      if (state_ff == S_WAIT && adone) begin
         case (step_ff)
            ST_H0: h0_in = hval;
            ST_H1: h1_in = hval;
            ST_Y:  y_in  = hval;
            ST_P0, ST_T0, ST_T1, ST_DH0, ST_DH1: tmp_in = ares;
            ST_ZO: zo_in = tmp_ff + ares + ZW'(w_ff[IX_B2]);
            ST_DZO1, ST_DZ01, ST_DZ11: d1_in = ares;
            ST_DZO2, ST_DZ02, ST_DZ12: dz_in = ares;
            ST_DY: dy_in = ares;
            ST_G:  g_in  = ares;
            ST_W6: w_in[IX_W20] = sat_w((ZW+1)'(w_ff[IX_W20]) - (ZW+1)'(ares));
            ST_W7: begin
               w_in[IX_W21] = sat_w((ZW+1)'(w_ff[IX_W21]) - (ZW+1)'(ares));
               w_in[IX_B2]  = sat_w((ZW+1)'(w_ff[IX_B2]) - (ZW+1)'(g_ff));
            end
            ST_S0: begin
               if (x0_ff) w_in[IX_W00] = sat_w((ZW+1)'(w_ff[IX_W00]) - (ZW+1)'(s));
               if (x1_ff) w_in[IX_W01] = sat_w((ZW+1)'(w_ff[IX_W01]) - (ZW+1)'(s));
               w_in[IX_B10] = sat_w((ZW+1)'(w_ff[IX_B10]) - (ZW+1)'(s));
            end
            ST_S1: begin
               if (x0_ff) w_in[IX_W10] = sat_w((ZW+1)'(w_ff[IX_W10]) - (ZW+1)'(s));
               if (x1_ff) w_in[IX_W11] = sat_w((ZW+1)'(w_ff[IX_W11]) - (ZW+1)'(s));
               w_in[IX_B11] = sat_w((ZW+1)'(w_ff[IX_B11]) - (ZW+1)'(s));
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_H0;
         rsp_valid_ff <= 1'b0;
         lr_ff        <= LR_RESET;
         w_ff[IX_W00] <= init_weight(9);
         w_ff[IX_W01] <= init_weight(-8);
         w_ff[IX_W10] <= init_weight(8);
         w_ff[IX_W11] <= init_weight(-9);
         w_ff[IX_B10] <= init_weight(2);
         w_ff[IX_B11] <= init_weight(-2);
         w_ff[IX_W20] <= init_weight(14);
         w_ff[IX_W21] <= init_weight(-14);
         w_ff[IX_B2]  <= init_weight(0);
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff        <= lr_in;
         w_ff         <= w_in;
      end
      train_ff    <= train_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      tgt_ff      <= tgt_in;
      z0_ff       <= z0_in;
      z1_ff       <= z1_in;
      zo_ff       <= zo_in;
      h0_ff       <= h0_in;
      h1_ff       <= h1_in;
      y_ff        <= y_in;
      tmp_ff      <= tmp_in;
      d1_ff       <= d1_in;
      dz_ff       <= dz_in;
      dy_ff       <= dy_in;
      g_ff        <= g_in;
      ow0_ff      <= ow0_in;
      ow1_ff      <= ow1_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_NEXT(a_start, clock, reset, accept, (state_ff == S_ISSUE && step_ff == ST_H0), "accepted beat did not start the sequence")
   `ASSERT_CLKD(a_done_wait, clock, reset, (adone |-> state_ff == S_WAIT), "shared unit finished outside wait")
   `ASSERT_NEXT(a_idle_weights, clock, reset, (state_ff == S_IDLE), ($stable(w_ff[IX_W20]) && $stable(w_ff[IX_B2])), "weights moved while idle")
   `ASSERT_NEXT(a_emit_hold, clock, reset, (state_ff == S_EMIT && rsp_valid_ff && !rsp_tready), (state_ff == S_EMIT), "result overwrote a pending beat")

endmodule
